### design/msp_pkg.sv
// Shared types and constants for the multi-stack shared pool.
package msp_pkg;

	localparam int NUM_STACKS_DEF  = 8;
	localparam int CAPACITY_DEF    = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam int STACK_ID_W = 3;
	localparam int DATA_W     = 32;
	localparam int CFG_W      = 4;

	localparam logic [CFG_W-1:0] STACKS_IN_USE_RST = 4'd8;

	typedef enum logic {
		KIND_PUSH = 1'b0,
		KIND_POP  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef struct packed {
		logic rd_en;
		logic push;
		logic pop;
	} pool_cmd_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} top_cmd_t;

endpackage

### design/msp_if.sv
// Request and response channel interfaces.
interface msp_req_if;
	logic                               valid;
	logic                               ready;
	msp_pkg::kind_t                     kind;
	logic [msp_pkg::STACK_ID_W-1:0]     stack_id;
	logic signed [msp_pkg::DATA_W-1:0]  push_value;

	modport source (output valid, kind, stack_id, push_value, input ready);
	modport sink (input valid, kind, stack_id, push_value, output ready);
endinterface

interface msp_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [msp_pkg::DATA_W-1:0]  pop_value;
	msp_pkg::status_t                   status;

	modport source (output valid, pop_value, status, input ready);
	modport sink (input valid, pop_value, status, output ready);
endinterface

### design/msp_top_tbl.sv
// Top-of-stack table: registered-read memory with per-stack valid bits.
module msp_top_tbl #(
	parameter int NUM_STACKS = msp_pkg::NUM_STACKS_DEF,
	parameter int SW         = 5,
	parameter int TW         = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  msp_pkg::top_cmd_t cmd,
	input  logic [TW-1:0]     rd_idx,
	input  logic [TW-1:0]     wr_idx,
	input  logic [SW-1:0]     wr_top,
	output logic [SW-1:0]     rd_top
);

	localparam logic [SW-1:0] NULL_SLOT = SW'(NUM_STACKS * 0 + (1 << SW) - 1);

	logic [SW-1:0]         mem [NUM_STACKS];
	logic [NUM_STACKS-1:0] vld_q;
	logic [SW-1:0]         rd_data_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_idx] <= wr_top;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_vld_q <= (int'(rd_idx) < NUM_STACKS) && vld_q[rd_idx];
			end
		end
	end

	// never-written stacks read as empty; any code >= capacity is null
	assign rd_top = rd_vld_q ? rd_data_q : NULL_SLOT;

endmodule

### design/msp_pool.sv
// Slot pool: link/value memory, free-list head and untouched-slot counter.
module msp_pool #(
	parameter int CAPACITY    = msp_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = msp_pkg::VALUE_WIDTH_DEF,
	parameter int SW          = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  msp_pkg::pool_cmd_t     cmd,
	input  logic [SW-1:0]          slot,
	input  logic [SW-1:0]          wr_link,
	input  logic [VALUE_WIDTH-1:0] wr_value,
	output logic [SW-1:0]          free_head,
	output logic [SW-1:0]          rd_link,
	output logic [VALUE_WIDTH-1:0] rd_value
);

	localparam int SLW = $clog2(CAPACITY);
	localparam int EW  = SW + VALUE_WIDTH;

	logic [EW-1:0]  mem [CAPACITY];
	logic [EW-1:0]  rd_q;
	logic           rd_fresh_q;
	logic [SW-1:0]  rd_slot_q;
	logic [SW-1:0]  free_head_q;
	logic [SW-1:0]  fresh_q;
	logic [SLW-1:0] addr;

	assign addr = slot[SLW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[addr] <= {wr_link, wr_value};
		end else if (cmd.pop) begin
			mem[addr] <= {free_head_q, rd_q[VALUE_WIDTH-1:0]};
		end
		if (cmd.rd_en) begin
			rd_q       <= mem[addr];
			rd_fresh_q <= slot >= fresh_q;
			rd_slot_q  <= slot;
		end
	end

	// slots at or above fresh_q were never taken and still chain in order
	assign rd_link  = rd_fresh_q ? rd_slot_q + SW'(1) : rd_q[EW-1:VALUE_WIDTH];
	assign rd_value = rd_q[VALUE_WIDTH-1:0];
	assign free_head = free_head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			fresh_q     <= '0;
		end else if (cmd.push) begin
			free_head_q <= rd_link;
			if (slot == fresh_q) begin
				fresh_q <= fresh_q + SW'(1);
			end
		end else if (cmd.pop) begin
			free_head_q <= slot;
		end
	end

endmodule

### design/multi_stack_shared_pool.sv
// Multi-stack shared pool: several LIFO stacks linked through one slot memory.
// Every push or pop request returns exactly one response. A request that reaches
// the pool registers its response after a top-table read, then a slot-memory read,
// then write-back with the response; a rejected request (invalid stack, full pool,
// empty stack) registers it after the top-table read alone. Either can wait while
// the previous response is still held. One request is in flight at a time; the next
// is taken in the cycle after the response is registered, while that response may
// still wait. A pool request is the slower kind: it has two memory reads in series.
// No clearing pass after reset: stack tops use valid bits and unused slots are
// tracked by a fill counter.
module multi_stack_shared_pool #(
	parameter int NUM_STACKS  = msp_pkg::NUM_STACKS_DEF,
	parameter int CAPACITY    = msp_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = msp_pkg::VALUE_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	msp_req_if.sink                    req,
	msp_rsp_if.source                  rsp,
	input  logic                       cfg_we,
	input  logic [msp_pkg::CFG_W-1:0]  cfg_wdata
);

	localparam int SW = $clog2(CAPACITY + 1);
	localparam int TW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam logic [SW-1:0] NULL_SLOT = SW'(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE,
		S_TOP,
		S_SLOT
	} state_t;

	state_t                          state_q;
	msp_pkg::kind_t                  kind_q;
	logic [msp_pkg::STACK_ID_W-1:0]  sid_q;
	logic [VALUE_WIDTH-1:0]          val_q;
	logic                            bad_q;
	logic [SW-1:0]                   cur_q;
	logic                            out_vld_q;
	logic [msp_pkg::DATA_W-1:0]      pop_value_q;
	msp_pkg::status_t                status_q;
	logic [msp_pkg::CFG_W-1:0]       su_q;

	logic                            out_free;
	logic                            commit;
	logic                            rsp_load;
	logic [SW-1:0]                   top_rd;
	logic [SW-1:0]                   free_head;
	logic [SW-1:0]                   rd_link;
	logic [VALUE_WIDTH-1:0]          rd_value;
	logic [SW-1:0]                   cur;
	logic [SW-1:0]                   pool_slot;
	logic [SW-1:0]                   top_wr;
	msp_pkg::status_t                fail_status;
	msp_pkg::top_cmd_t               top_cmd;
	msp_pkg::pool_cmd_t              pool_cmd;
	logic [63:0]                     in_ext;
	logic [63:0]                     out_ext;
	logic                            bad_in;

	assign out_free  = !out_vld_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_vld_q;
	assign rsp.pop_value = pop_value_q;
	assign rsp.status    = status_q;

	assign in_ext  = {32'b0, req.push_value};
	assign out_ext = 64'(rd_value);
	assign bad_in  = ({1'b0, req.stack_id} >= su_q) || (int'(req.stack_id) >= NUM_STACKS);

	always_comb begin
		cur = (kind_q == msp_pkg::KIND_POP) ? top_rd : free_head;
		if (bad_q) begin
			fail_status = msp_pkg::ST_INVALID;
		end else if (cur >= NULL_SLOT) begin
			fail_status = (kind_q == msp_pkg::KIND_POP) ? msp_pkg::ST_EMPTY
				: msp_pkg::ST_FULL;
		end else begin
			fail_status = msp_pkg::ST_OK;
		end
	end

	assign commit = (state_q == S_SLOT) && out_free;
	assign rsp_load = ((state_q == S_TOP) && (fail_status != msp_pkg::ST_OK) && out_free)
		|| commit;

	assign top_cmd.rd_en = req.valid && req.ready;
	assign top_cmd.wr_en = commit;
	assign pool_cmd.rd_en = (state_q == S_TOP) && (fail_status == msp_pkg::ST_OK);
	assign pool_cmd.push  = commit && (kind_q == msp_pkg::KIND_PUSH);
	assign pool_cmd.pop   = commit && (kind_q == msp_pkg::KIND_POP);
	assign pool_slot = (state_q == S_SLOT) ? cur_q : cur;
	assign top_wr    = (kind_q == msp_pkg::KIND_PUSH) ? cur_q : rd_link;

	msp_top_tbl #(
		.NUM_STACKS (NUM_STACKS),
		.SW         (SW),
		.TW         (TW)
	) u_top_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (top_cmd),
		.rd_idx (TW'(req.stack_id)),
		.wr_idx (TW'(sid_q)),
		.wr_top (top_wr),
		.rd_top (top_rd)
	);

	msp_pool #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH),
		.SW          (SW)
	) u_pool (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (pool_cmd),
		.slot      (pool_slot),
		.wr_link   (top_rd),
		.wr_value  (val_q),
		.free_head (free_head),
		.rd_link   (rd_link),
		.rd_value  (rd_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			su_q <= msp_pkg::STACKS_IN_USE_RST;
		end else if (cfg_we) begin
			su_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						kind_q  <= req.kind;
						sid_q   <= req.stack_id;
						val_q   <= in_ext[VALUE_WIDTH-1:0];
						bad_q   <= bad_in;
						state_q <= S_TOP;
					end
				end
				S_TOP: begin
					if (fail_status != msp_pkg::ST_OK) begin
						if (out_free) begin
							pop_value_q <= (kind_q == msp_pkg::KIND_POP) ? '1 : '0;
							status_q    <= fail_status;
							state_q     <= S_IDLE;
						end
					end else begin
						cur_q   <= cur;
						state_q <= S_SLOT;
					end
				end
				S_SLOT: begin
					if (out_free) begin
						pop_value_q <= (kind_q == msp_pkg::KIND_POP) ? out_ext[31:0] : '0;
						status_q    <= msp_pkg::ST_OK;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### design/msp_chk.sv
// Port-level checker for the multi-stack shared pool, bound to the top level.
module msp_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic [msp_pkg::DATA_W-1:0]        rsp_pop_value,
	input logic [1:0]                        rsp_status
);

	logic [1:0] pend_q;
	logic       acc;
	logic       dlv;

	assign acc = req_valid && req_ready;
	assign dlv = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(acc) - 2'(dlv);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pop_value)
			&& $stable(rsp_status))
		else $error("response changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !req_ready)
		else $error("request taken while one is in flight");

	a_no_orphan_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without a pending request");

	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == msp_pkg::ST_EMPTY |-> rsp_pop_value == '1)
		else $error("failed pop must return all ones");

	a_full_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == msp_pkg::ST_FULL |-> rsp_pop_value == '0)
		else $error("push must return zero");

endmodule

bind multi_stack_shared_pool msp_chk u_msp_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_pop_value (rsp.pop_value),
	.rsp_status    (rsp.status)
);

### tb/sv/multi_stack_shared_pool_tb.sv
// Testbench for multi_stack_shared_pool: random and directed requests checked by a predictor.
module multi_stack_shared_pool_tb;

	localparam logic [4:0] NO_SLOT = 5'(msp_pkg::CAPACITY_DEF);

	typedef struct {
		logic [msp_pkg::DATA_W-1:0] pop_value;
		msp_pkg::status_t           status;
	} stack_result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [msp_pkg::CFG_W-1:0] cfg_wdata;

	msp_req_if req_ch ();
	msp_rsp_if rsp_ch ();

	multi_stack_shared_pool dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state
	logic [4:0]                 top_slot   [msp_pkg::NUM_STACKS_DEF];
	logic [4:0]                 link_slot  [msp_pkg::CAPACITY_DEF];
	logic [msp_pkg::DATA_W-1:0] slot_value [msp_pkg::CAPACITY_DEF];
	logic [4:0]                 free_slot;
	logic [msp_pkg::CFG_W-1:0]  stack_limit;

	stack_result_t pending_results [$];
	int            mismatch_count;
	int            hold_left;
	bit            no_gaps;

	always #10 clk = ~clk;

	function automatic void reset_pool_model();
		stack_limit = msp_pkg::STACKS_IN_USE_RST;
		free_slot   = 5'd0;
		for (int i = 0; i < msp_pkg::NUM_STACKS_DEF; i++)
			top_slot[i] = NO_SLOT;
		for (int i = 0; i < msp_pkg::CAPACITY_DEF; i++) begin
			link_slot[i]  = 5'(i + 1);
			slot_value[i] = '0;
		end
	endfunction

	function automatic stack_result_t apply_stack_op(input msp_pkg::kind_t k,
			input logic [2:0] sid, input logic [msp_pkg::DATA_W-1:0] val);
		stack_result_t r;
		logic [4:0]    cur;
		r.pop_value = (k == msp_pkg::KIND_POP) ? '1 : '0;
		r.status    = msp_pkg::ST_OK;
		if ({1'b0, sid} >= stack_limit || int'(sid) >= msp_pkg::NUM_STACKS_DEF) begin
			r.status = msp_pkg::ST_INVALID;
		end else if (k == msp_pkg::KIND_PUSH) begin
			cur = free_slot;
			if (cur >= NO_SLOT) begin
				r.status = msp_pkg::ST_FULL;
			end else begin
				free_slot       = link_slot[cur];
				link_slot[cur]  = top_slot[sid];
				top_slot[sid]   = cur;
				slot_value[cur] = val;
			end
		end else begin
			cur = top_slot[sid];
			if (cur >= NO_SLOT) begin
				r.status = msp_pkg::ST_EMPTY;
			end else begin
				r.pop_value    = slot_value[cur];
				top_slot[sid]  = link_slot[cur];
				link_slot[cur] = free_slot;
				free_slot      = cur;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// send one request; returns at the edge where it was accepted
	task automatic send_request(input msp_pkg::kind_t k, input logic [2:0] sid,
			input logic [msp_pkg::DATA_W-1:0] val);
		int gap;
		if (!no_gaps && $urandom_range(99) < 37) begin
			gap = $urandom_range(4, 1);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.kind       <= k;
		req_ch.stack_id   <= sid;
		req_ch.push_value <= val;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pending_results.push_back(apply_stack_op(k, sid, val));
	endtask

	task automatic send_random(input int push_pct, input int max_sid);
		send_request(($urandom_range(99) < push_pct) ? msp_pkg::KIND_PUSH : msp_pkg::KIND_POP,
			3'($urandom_range(max_sid)), $urandom());
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_stack_limit(input logic [msp_pkg::CFG_W-1:0] v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		stack_limit = v;
	endtask

	task automatic test_directed();
		send_request(msp_pkg::KIND_PUSH, 3'd0, 32'h7FFF_FFFF);
		send_request(msp_pkg::KIND_PUSH, 3'd0, 32'h8000_0000);
		send_request(msp_pkg::KIND_PUSH, 3'd7, 32'h0000_0000);
		send_request(msp_pkg::KIND_PUSH, 3'd7, 32'hFFFF_FFFF);
		send_request(msp_pkg::KIND_PUSH, 3'd3, 32'h5A5A_A5A5);
		send_request(msp_pkg::KIND_POP, 3'd0, $urandom());
		send_request(msp_pkg::KIND_POP, 3'd0, $urandom());
		send_request(msp_pkg::KIND_POP, 3'd0, $urandom());
		send_request(msp_pkg::KIND_POP, 3'd7, $urandom());
		send_request(msp_pkg::KIND_POP, 3'd7, $urandom());
		send_request(msp_pkg::KIND_POP, 3'd7, $urandom());
		send_request(msp_pkg::KIND_POP, 3'd3, $urandom());
		send_request(msp_pkg::KIND_POP, 3'd3, $urandom());
		send_request(msp_pkg::KIND_POP, 3'd5, $urandom());
		send_request(msp_pkg::KIND_PUSH, 3'd5, 32'hA5A5_5A5A);
		send_request(msp_pkg::KIND_POP, 3'd5, 32'hFFFF_FFFF);
	endtask

	task automatic test_stack_limits();
		set_stack_limit(4'd3);
		send_request(msp_pkg::KIND_PUSH, 3'd2, 32'h1234_5678);
		send_request(msp_pkg::KIND_PUSH, 3'd3, 32'h0BAD_0BAD);
		send_request(msp_pkg::KIND_POP, 3'd7, $urandom());
		send_request(msp_pkg::KIND_POP, 3'd2, $urandom());
		set_stack_limit(4'd0);
		send_request(msp_pkg::KIND_PUSH, 3'd0, $urandom());
		send_request(msp_pkg::KIND_POP, 3'd0, $urandom());
		set_stack_limit(4'd15);
		send_request(msp_pkg::KIND_PUSH, 3'd7, $urandom());
		send_request(msp_pkg::KIND_POP, 3'd7, $urandom());
		set_stack_limit(4'd1);
		send_request(msp_pkg::KIND_PUSH, 3'd0, $urandom());
		send_request(msp_pkg::KIND_PUSH, 3'd1, $urandom());
		send_request(msp_pkg::KIND_POP, 3'd0, $urandom());
		set_stack_limit(4'd8);
	endtask

	task automatic test_pool_full();
		for (int i = 0; i < msp_pkg::CAPACITY_DEF + 3; i++)
			send_random(100, 7);
		for (int i = 0; i < msp_pkg::CAPACITY_DEF; i++)
			send_random(0, 7);
		for (int s = 0; s < msp_pkg::NUM_STACKS_DEF; s++)
			for (int j = 0; j < 3; j++)
				send_request(msp_pkg::KIND_POP, 3'(s), $urandom());
	endtask

	task automatic test_backpressure();
		wait_drained();
		hold_left = 300;
		for (int i = 0; i < 40; i++)
			send_random(60, 7);
	endtask

	task automatic test_random_traffic();
		int pct;
		for (int phase = 0; phase < 28; phase++) begin
			if (phase % 4 == 0)
				set_stack_limit(($urandom_range(99) < 60) ? 4'd8 : 4'($urandom_range(15)));
			no_gaps = (phase == 10 || phase == 11);
			case ($urandom_range(2))
				0: pct = 25;
				1: pct = 50;
				default: pct = 80;
			endcase
			for (int i = 0; i < 50; i++)
				send_random(pct, 7);
		end
		no_gaps = 0;
	endtask

	// response side: random ready, long hold when asked, check every response
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected response value=%h status=%0d",
						rsp_ch.pop_value, rsp_ch.status));
				end else begin
					stack_result_t want;
					want = pending_results.pop_front();
					if (rsp_ch.status !== want.status)
						report_mismatch($sformatf("status %0d, wanted %0d",
							rsp_ch.status, want.status));
					if (rsp_ch.pop_value !== want.pop_value)
						report_mismatch($sformatf("pop_value %h, wanted %h",
							rsp_ch.pop_value, want.pop_value));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= no_gaps || ($urandom_range(99) >= 37);
			end
		end
	end

	initial begin
		#8_000_000;
		$display("multi_stack_shared_pool test failed");
		$finish;
	end

	initial begin
		clk            = 1'b0;
		mismatch_count = 0;
		hold_left      = 0;
		no_gaps        = 0;
		reset_pool_model();
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= '0;
		req_ch.valid      <= 1'b0;
		req_ch.kind       <= msp_pkg::KIND_PUSH;
		req_ch.stack_id   <= '0;
		req_ch.push_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_stack_limits();
		test_pool_full();
		test_backpressure();
		test_random_traffic();
		test_pool_full();

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("multi_stack_shared_pool test passed");
		else
			$display("multi_stack_shared_pool test failed");
		$finish;
	end

endmodule

### multi_stack_shared_pool.f
design/msp_pkg.sv
design/msp_if.sv
design/msp_top_tbl.sv
design/msp_pool.sv
design/multi_stack_shared_pool.sv
design/msp_chk.sv
tb/sv/multi_stack_shared_pool_tb.sv
